@@ design/nps_pkg.sv @@
package nps_pkg;

    localparam int DATA_W  = 16;
    localparam int DIST_W  = 34;
    localparam int INDEX_W = 10;
    localparam int SQ_W    = 32;
    // wide enough for a point count at the largest supported table size
    localparam int POS_W   = 17;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] coord_x;
        logic signed [DATA_W-1:0] coord_y;
        logic signed [DATA_W-1:0] coord_z;
        logic signed [DATA_W-1:0] normal_x;
        logic signed [DATA_W-1:0] normal_y;
        logic signed [DATA_W-1:0] normal_z;
    } in_t;

    typedef struct packed {
        logic                     found;
        logic [INDEX_W-1:0]       best_index;
        logic signed [DATA_W-1:0] best_x;
        logic signed [DATA_W-1:0] best_y;
        logic signed [DATA_W-1:0] best_z;
        logic signed [DATA_W-1:0] best_nx;
        logic signed [DATA_W-1:0] best_ny;
        logic signed [DATA_W-1:0] best_nz;
        logic [DIST_W-1:0]        best_dist_sq;
    } out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] nx;
        logic signed [DATA_W-1:0] ny;
        logic signed [DATA_W-1:0] nz;
    } point_t;

    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } op_t;

    // pos is the write address for a load and the point count for a query
    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        point_t           pt;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

@@ design/nps_front.sv @@
module nps_front #(
    parameter int MAX_POINTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nps_pkg::in_t  in_data,
    input  logic          q_full,
    output logic          push,
    output nps_pkg::job_t job
);
    import nps_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        push       = 1'b0;
        count_next = count_reg;
        job.op     = OP_LOAD;
        job.pos    = POS_W'(count_reg);
        job.pt.x   = in_data.coord_x;
        job.pt.y   = in_data.coord_y;
        job.pt.z   = in_data.coord_z;
        job.pt.nx  = in_data.normal_x;
        job.pt.ny  = in_data.normal_y;
        job.pt.nz  = in_data.normal_z;
        unique case (in_data.cmd)
            CMD_LOAD:
            begin
                // loads past capacity are dropped here
                if (accept && (count_reg < CNT_W'(MAX_POINTS)))
                begin
                    push       = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_QUERY:
            begin
                job.op = OP_QUERY;
                push   = accept;
            end
            CMD_CLEAR:
            begin
                if (accept)
                begin
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ design/nps_queue.sv @@
module nps_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nps_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output nps_pkg::job_t head
);
    import nps_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (fill_reg == 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ design/nps_back.sv @@
module nps_back #(
    parameter int MAX_POINTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  nps_pkg::job_t job,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output nps_pkg::out_t out_data
);
    import nps_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    state_t state_reg;
    state_t state_next;

    point_t mem [MAX_POINTS];

    logic mem_we;
    logic start;
    logic issue;
    logic issuing;
    logic out_load;
    logic query_empty;

    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  n_reg;
    logic signed [DATA_W-1:0] qx_reg;
    logic signed [DATA_W-1:0] qy_reg;
    logic signed [DATA_W-1:0] qz_reg;

    // read stage
    logic              v1_reg;
    logic [IDX_W-1:0]  idx1_reg;
    point_t            rd_pt_reg;

    // square stage
    logic              v2_reg;
    logic [IDX_W-1:0]  idx2_reg;
    point_t            pt2_reg;
    logic [SQ_W-1:0]   sq_x_reg;
    logic [SQ_W-1:0]   sq_y_reg;
    logic [SQ_W-1:0]   sq_z_reg;

    logic signed [DATA_W:0]     dx;
    logic signed [DATA_W:0]     dy;
    logic signed [DATA_W:0]     dz;
    logic signed [2*DATA_W+1:0] px;
    logic signed [2*DATA_W+1:0] py;
    logic signed [2*DATA_W+1:0] pz;
    logic [DIST_W-1:0]          dsum;
    logic                       take;

    logic              best_found_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    point_t            best_pt_reg;

    logic              out_valid_reg;
    out_t              out_data_reg;

    assign issuing     = (issue_cnt_reg != n_reg);
    assign query_empty = (job.pos[CNT_W-1:0] == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (job.op == OP_QUERY))
                begin
                    state_next = query_empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issuing && !v1_reg && !v2_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        start    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && (job.op == OP_LOAD);
                start  = q_valid && (job.op == OP_QUERY);
            end
            ST_SCAN:
            begin
                issue = issuing;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    // point table, one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[job.pos[IDX_W-1:0]] <= job.pt;
        end
        if (issue)
        begin
            rd_pt_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
            idx1_reg  <= issue_cnt_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        dx   = {qx_reg[DATA_W-1], qx_reg} - {rd_pt_reg.x[DATA_W-1], rd_pt_reg.x};
        dy   = {qy_reg[DATA_W-1], qy_reg} - {rd_pt_reg.y[DATA_W-1], rd_pt_reg.y};
        dz   = {qz_reg[DATA_W-1], qz_reg} - {rd_pt_reg.z[DATA_W-1], rd_pt_reg.z};
        px   = dx * dx;
        py   = dy * dy;
        pz   = dz * dz;
        dsum = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
        // strict compare keeps the earliest index on a tie
        take = v2_reg && ((idx2_reg == '0) || (dsum < best_d_reg));
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg <= px[SQ_W-1:0];
        sq_y_reg <= py[SQ_W-1:0];
        sq_z_reg <= pz[SQ_W-1:0];
        pt2_reg  <= rd_pt_reg;
        idx2_reg <= idx1_reg;
        if (start)
        begin
            qx_reg       <= job.pt.x;
            qy_reg       <= job.pt.y;
            qz_reg       <= job.pt.z;
            best_d_reg   <= '0;
            best_idx_reg <= '0;
            best_pt_reg  <= '0;
        end
        else if (take)
        begin
            best_d_reg   <= dsum;
            best_idx_reg <= idx2_reg;
            best_pt_reg  <= pt2_reg;
        end
        if (out_load)
        begin
            out_data_reg.found        <= best_found_reg;
            out_data_reg.best_index   <= INDEX_W'(best_idx_reg);
            out_data_reg.best_x       <= best_pt_reg.x;
            out_data_reg.best_y       <= best_pt_reg.y;
            out_data_reg.best_z       <= best_pt_reg.z;
            out_data_reg.best_nx      <= best_pt_reg.nx;
            out_data_reg.best_ny      <= best_pt_reg.ny;
            out_data_reg.best_nz      <= best_pt_reg.nz;
            out_data_reg.best_dist_sq <= best_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_cnt_reg  <= '0;
            n_reg          <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (start)
            begin
                n_reg          <= job.pos[CNT_W-1:0];
                issue_cnt_reg  <= '0;
                best_found_reg <= !query_empty;
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (!v1_reg && !v2_reg))
        else $error("scan pipeline busy outside a scan");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= n_reg))
        else $error("scan issued past the point count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |->
            ((out_data_reg.best_dist_sq == '0) && (out_data_reg.best_index == '0)))
        else $error("empty-table result carries nonzero fields");
`endif

endmodule

@@ design/nearest_point_search_core.sv @@
// nearest point search over a table of 3d points with normals
// input channel (in_valid/in_ready/in_data) carries load, query and clear
// transactions; output channel (out_valid/out_ready/out_data) returns one
// result per query and nothing for loads, clears or unused command codes.
// loads append a point at the next free index and are dropped once the
// table holds MAX_POINTS entries; clear empties the table at once.
// a front stage takes transactions and tracks the point count, a two-entry
// queue feeds a back stage that owns the point memory and runs the scan.
// a query scans the n stored points, one point per cycle through the
// single memory read port, then a squaring stage and a compare stage,
// and a query on an empty table skips the scan. the result sits in an
// output register until taken; while it waits, queued loads still
// execute but the next query result holds in the back stage, and the
// queue fills before in_ready drops.
// reset empties the table and the queue and drops any pending result.
module nearest_point_search_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nps_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output nps_pkg::out_t out_data
);
    import nps_pkg::*;

    logic q_full;
    logic push;
    job_t push_job;
    logic q_valid;
    logic q_pop;
    job_t head_job;

    nps_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    nps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_job)
    );

    nps_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .job       (head_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
